FILE: rtl/abb_pkg.sv
`timescale 1ns / 1ps

package abb_pkg;

   localparam int PIX_W      = 32;
   localparam int CH_W       = 8;
   localparam int CHANNELS   = 4;
   localparam int SUM_W      = 13;
   localparam int RADIUS_W   = 4;
   localparam int RESULT_LIMIT = 16;

   localparam int MAX_RADIUS_DEF = 15;
   localparam int MAX_WIDTH_DEF  = 4096;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = 1'b0;

endpackage

FILE: rtl/abb_cell.sv
`timescale 1ns / 1ps

// One tap of the pixel window; shifts toward older taps on each input transfer.
module abb_cell (
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [abb_pkg::PIX_W-1:0] pixel_in,
   output logic [abb_pkg::PIX_W-1:0] pixel_out
);
   import abb_pkg::*;

   logic [PIX_W-1:0] pixel_ff;
   logic [PIX_W-1:0] pixel_in_mux;

   assign pixel_in_mux = shift_en ? pixel_in : pixel_ff;

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in_mux;
   end

   assign pixel_out = pixel_ff;

endmodule

FILE: rtl/abb_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module abb_div #(
   parameter int DIV_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [abb_pkg::SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic [abb_pkg::CH_W-1:0]  quotient,
   output logic                      done
);
   import abb_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // a mean never exceeds one channel's range
   assign quotient = quo_ff[CH_W-1:0];
   assign done     = done_ff;

endmodule

FILE: rtl/argb_row_box_blur.sv
`timescale 1ns / 1ps

// Each input transfer goes through a scan step and, for every output it releases
// (2R+1 window taps, R = effective radius), sums the taps one per cycle and then divides.
// A new pixel is taken only after all outputs owed by the previous one are computed.
// Synchronous reset clears the sequencer, row counters and result valid; radius resets to 5.
module argb_row_box_blur #(
   parameter int MAX_RADIUS = abb_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = abb_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input pixels
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [abb_pkg::PIX_W-1:0]      req_tdata,   // pixel_in
   input  logic                           req_tlast,   // row_end
   // blurred pixels
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [abb_pkg::PIX_W-1:0]      rsp_tdata,   // pixel_out
   output logic                           rsp_tlast,   // row_last
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [abb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [abb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [abb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import abb_pkg::*;

   localparam int WD    = 2 * MAX_RADIUS + 1;
   localparam int BW    = $clog2(WD);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int DIV_W = RW + 1;
   localparam int TW    = $clog2(WD);
   localparam int NW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int PW    = $clog2(MAX_WIDTH + 4 * MAX_RADIUS + 2) + 1;
   localparam int KW    = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [RW-1:0]       r_ff, r_in;
   logic [NW-1:0]       seen_ff, seen_in;
   logic [CW-1:0]       sent_ff, sent_in;
   logic [KW-1:0]       count_ff, count_in;
   logic                end_ff, end_in;
   logic [TW-1:0]       tap_ff, tap_in;
   logic [PIX_W-1:0]    first_ff, first_in;
   logic [SUM_W-1:0]    acc_ff [CHANNELS];
   logic [SUM_W-1:0]    acc_in [CHANNELS];
   logic [SUM_W-1:0]    acc_next [CHANNELS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [PIX_W-1:0]    cell_q [WD];
   logic [PW-1:0]       sent_p, n_p, r_p;
   logic signed [PW-1:0] pos, pos_c, back_full;
   logic [BW-1:0]       back;
   logic [PIX_W-1:0]    tap_pix;
   logic                need;
   logic                last_tap;
   logic                div_start;
   logic [DIV_W-1:0]    divisor;
   logic [CH_W-1:0]     quo [CHANNELS];
   logic [CHANNELS-1:0] div_done;
   logic                out_free;
   logic [RW-1:0]       r_eff;

   // ---------------- configuration ----------------
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      if (csr_wr && csr_idx == REG_RADIUS) begin
         radius_in = csr_pwdata[RADIUS_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RADIUS: csr_prdata = CSR_DATA_W'(radius_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- window chain ----------------
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   for (genvar k = 0; k < WD; k++) begin : g_cell
      abb_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .pixel_in  ((k == 0) ? req_tdata : cell_q[(k == 0) ? 0 : k - 1]),
         .pixel_out (cell_q[k])
      );
   end

   // ---------------- tap selection ----------------
   assign sent_p = PW'(sent_ff);
   assign n_p    = PW'(seen_ff);
   assign r_p    = PW'(r_ff);

   always_comb begin
      pos       = $signed(sent_p) - $signed(r_p) + $signed(PW'(tap_ff));
      pos_c     = (pos > $signed(n_p)) ? $signed(n_p) : pos;
      back_full = $signed(n_p) - pos_c;
      if ($unsigned(back_full) > PW'(WD - 1)) begin
         back = BW'(WD - 1);
      end else begin
         back = BW'($unsigned(back_full));
      end
      // positions before the row start read the row's first pixel
      tap_pix = (pos < 0) ? first_ff : cell_q[back];
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_acc
      assign acc_next[c] = acc_ff[c] +
                           SUM_W'(tap_pix[CH_W*(CHANNELS-1-c) +: CH_W]);
   end

   assign need = (count_ff < KW'(RESULT_LIMIT)) && (sent_p <= n_p) &&
                 (end_ff || (sent_p + r_p <= n_p));
   assign last_tap  = (32'(tap_ff) == 32'(r_ff) * 2);
   assign div_start = (state_ff == ST_ACC) && last_tap;
   assign divisor   = {r_ff, 1'b1};
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      seen_in      = seen_ff;
      sent_in      = sent_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      tap_in       = tap_ff;
      first_in     = first_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r_in     = r_eff;
               end_in   = req_tlast || (32'(seen_ff) >= 32'(MAX_WIDTH - 1));
               count_in = '0;
               if (seen_ff == '0) begin
                  first_in = req_tdata;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (need) begin
               tap_in = '0;
               for (int c = 0; c < CHANNELS; c++) begin
                  acc_in[c] = '0;
               end
               state_in = ST_ACC;
            end else begin
               if (end_ff) begin
                  seen_in = '0;
                  sent_in = '0;
               end else begin
                  seen_in = NW'(seen_ff + 1'b1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_ACC: begin
            acc_in = acc_next;
            tap_in = TW'(tap_ff + 1'b1);
            if (last_tap) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done[0] && out_free) begin
               rsp_valid_in = 1'b1;
               for (int c = 0; c < CHANNELS; c++) begin
                  rsp_data_in[CH_W*(CHANNELS-1-c) +: CH_W] = quo[c];
               end
               rsp_last_in = end_ff && (sent_p == n_p);
               sent_in     = CW'(sent_ff + 1'b1);
               count_in    = KW'(count_ff + 1'b1);
               state_in    = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_div
      abb_div #(
         .DIV_W (DIV_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (acc_next[c]),
         .divisor  (divisor),
         .quotient (quo[c]),
         .done     (div_done[c])
      );
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      end_ff      <= end_in;
      tap_ff      <= tap_in;
      first_ff    <= first_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         seen_ff      <= '0;
         sent_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         seen_ff      <= seen_in;
         sent_ff      <= sent_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
